// ----- design/xcfr_pkg.sv -----
// Shared types and constants of the XOR checksum frame receiver.
// Used by xcfr_front, xcfr_queue, xcfr_back and the top level.
// No dependencies.
package xcfr_pkg;

	// Configuration register indexes
	localparam logic REG_LEN_CHECK_EN = 1'b0;
	localparam logic REG_EXP_LEN      = 1'b1;

	// Result item kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Depth of the queue between parser and output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Bits of packed result data on the output stream, rounded to bytes
	localparam int ODATA_RAW_W = 8 + 3 + 8 + 16;
	localparam int ODATA_W     = ((ODATA_RAW_W + 7) / 8) * 8;

	// Initial value of the running checksum
	localparam logic [7:0] XOR_SEED = 8'hFF;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_ZERO_SIZE    = 3'd1,
		ST_LEN_MISMATCH = 3'd2,
		ST_TOO_LONG     = 3'd3,
		ST_BAD_CHECKSUM = 3'd4
	} xcfr_status_t;

	// One result item as it travels through the queue
	typedef struct packed {
		logic         kind;
		logic [7:0]   data;
		xcfr_status_t status;
		logic [7:0]   opcode;
		logic [15:0]  count;
	} xcfr_item_t;

	// Queue fill status seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} xcfr_qstat_t;

endpackage

// ----- design/xor_checksum_frame_receiver_unit.sv -----
// Receives length-prefixed frames (opcode, 16-bit little-endian size, payload,
// XOR checksum) one byte per transfer and streams out each payload byte followed
// by one status item per frame. A byte is taken every clock cycle while the
// four-entry result queue has room; the parser updates its state at the edge
// that accepts a byte; a result caused by that byte is pushed into the queue at
// that edge and then moved to the output register. While the queue is full every
// input byte waits, including opcode, size and idle bytes that cause no result.
// Configuration is written through cfg_we.
// Top level; depends on xcfr_pkg, xcfr_front, xcfr_queue and xcfr_back.
module xor_checksum_frame_receiver_unit #(
	parameter int BUF_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	// Byte input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	// Result output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [xcfr_pkg::ODATA_W-1:0] m_axis_tdata,
	// [7:0] payload_byte, [10:8] frame_status, [18:11] frame_opcode,
	// [34:19] payload_count, [39:35] zero
	output logic        m_axis_tuser,   // [0] item_kind
	output logic        m_axis_tlast    // last_item
);

	logic                              accept;
	logic                              push;
	logic                              pop;
	xcfr_pkg::xcfr_item_t              push_item;
	xcfr_pkg::xcfr_item_t              head_item;
	xcfr_pkg::xcfr_qstat_t             qstat;
	logic [xcfr_pkg::QCNT_W-1:0]       fill;

	assign s_axis_tready = !qstat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	xcfr_front #(
		.BUF_BYTES(BUF_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.rx_byte    (s_axis_tdata),
		.frame_start(s_axis_tuser),
		.push       (push),
		.push_item  (push_item)
	);

	xcfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head_item(head_item),
		.qstat    (qstat),
		.fill     (fill)
	);

	xcfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.qstat        (qstat),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// A push is never lost: the parser only produces items for accepted bytes
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("result pushed into a full queue");

	// Queue fill stays in range
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= xcfr_pkg::QCNT_W'(xcfr_pkg::QDEPTH))
		else $error("queue fill count out of range");

	// Payload items carry no status and no count
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == xcfr_pkg::KIND_PAYLOAD)) |->
		(m_axis_tdata[34:8 + 3 + 8] == 16'd0 && m_axis_tdata[10:8] == 3'd0))
		else $error("payload item with status or count set");

	// An item popped from a nonempty queue shows up on the output next cycle
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid)
		else $error("popped item did not reach the output register");

endmodule

// ----- design/xcfr_front.sv -----
// Front end of the frame receiver: frame parser, checksum and size checks.
// Holds the configuration registers and pushes result items to the queue.
// Depends on xcfr_pkg.
module xcfr_front #(
	parameter int BUF_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_addr,
	input  logic [15:0]          cfg_wdata,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	output logic                 push,
	output xcfr_pkg::xcfr_item_t push_item
);

	localparam logic [17:0] BUF_LIMIT = 18'(BUF_BYTES);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SIZE_LO,
		PH_SIZE_HI,
		PH_BODY
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  opcode_q;
	logic [15:0] size_q;
	logic [15:0] left_q;
	logic [7:0]  xor_q;
	logic        len_chk_q;
	logic [15:0] exp_len_q;

	logic [15:0]           size_full;
	logic [15:0]           left_dec;
	logic [7:0]            xor_next;
	xcfr_pkg::xcfr_status_t size_status;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_chk_q <= 1'b0;
			exp_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				xcfr_pkg::REG_LEN_CHECK_EN: len_chk_q <= cfg_wdata[0];
				xcfr_pkg::REG_EXP_LEN:      exp_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Size as it stands once the high byte arrives, and its checks in priority order
	assign size_full = {rx_byte, size_q[7:0]};
	assign left_dec  = left_q - 16'd1;
	assign xor_next  = xor_q ^ rx_byte;

	always_comb begin
		size_status = xcfr_pkg::ST_OK;
		if (size_full == 16'd0)
			size_status = xcfr_pkg::ST_ZERO_SIZE;
		else if (({2'b00, size_full} + 18'd3) > BUF_LIMIT)
			size_status = xcfr_pkg::ST_TOO_LONG;
		else if (len_chk_q && ({1'b0, size_full} != ({1'b0, exp_len_q} + 17'd1)))
			size_status = xcfr_pkg::ST_LEN_MISMATCH;
	end

	// Classify the byte and build the result item
	always_comb begin
		push             = 1'b0;
		push_item.kind   = xcfr_pkg::KIND_PAYLOAD;
		push_item.data   = 8'h00;
		push_item.status = xcfr_pkg::ST_OK;
		push_item.opcode = opcode_q;
		push_item.count  = 16'd0;
		if (accept && !frame_start) begin
			case (phase_q)
				PH_SIZE_HI: begin
					if (size_status != xcfr_pkg::ST_OK) begin
						push             = 1'b1;
						push_item.kind   = xcfr_pkg::KIND_STATUS;
						push_item.status = size_status;
					end
				end
				PH_BODY: begin
					push = 1'b1;
					if (left_dec != 16'd0) begin
						push_item.data = rx_byte;
					end else begin
						push_item.kind   = xcfr_pkg::KIND_STATUS;
						push_item.status = (xor_next == 8'h00) ? xcfr_pkg::ST_OK
							: xcfr_pkg::ST_BAD_CHECKSUM;
						push_item.count  = size_q - 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the frame state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			opcode_q <= 8'h00;
			size_q   <= 16'd0;
			left_q   <= 16'd0;
			xor_q    <= xcfr_pkg::XOR_SEED;
		end else if (accept) begin
			if (frame_start) begin
				opcode_q <= rx_byte;
				xor_q    <= xcfr_pkg::XOR_SEED ^ rx_byte;
				size_q   <= 16'd0;
				left_q   <= 16'd0;
				phase_q  <= PH_SIZE_LO;
			end else begin
				case (phase_q)
					PH_SIZE_LO: begin
						xor_q   <= xor_next;
						size_q  <= {8'h00, rx_byte};
						phase_q <= PH_SIZE_HI;
					end
					PH_SIZE_HI: begin
						xor_q  <= xor_next;
						size_q <= size_full;
						if (size_status != xcfr_pkg::ST_OK) begin
							phase_q <= PH_IDLE;
						end else begin
							left_q  <= size_full;
							phase_q <= PH_BODY;
						end
					end
					PH_BODY: begin
						xor_q  <= xor_next;
						left_q <= left_dec;
						if (left_dec == 16'd0)
							phase_q <= PH_IDLE;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- design/xcfr_queue.sv -----
// Short FIFO of result items between the parser and the output stage.
// Lets either side stall on its own.
// Depends on xcfr_pkg.
module xcfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  xcfr_pkg::xcfr_item_t  push_item,
	input  logic                  pop,
	output xcfr_pkg::xcfr_item_t  head_item,
	output xcfr_pkg::xcfr_qstat_t qstat,
	output logic [xcfr_pkg::QCNT_W-1:0] fill
);

	xcfr_pkg::xcfr_item_t              slot_q [xcfr_pkg::QDEPTH];
	logic [xcfr_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [xcfr_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [xcfr_pkg::QCNT_W-1:0]       cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign qstat.full  = (cnt_q == xcfr_pkg::QCNT_W'(xcfr_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head_item   = slot_q[rd_ptr_q];
	assign fill        = cnt_q;

	// Store incoming items
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- design/xcfr_back.sv -----
// Output stage of the frame receiver: registered result stream.
// Pulls items from the queue and packs them onto the master stream.
// Depends on xcfr_pkg.
module xcfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  xcfr_pkg::xcfr_item_t          head_item,
	input  xcfr_pkg::xcfr_qstat_t         qstat,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [xcfr_pkg::ODATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);

	logic                 out_valid_q;
	xcfr_pkg::xcfr_item_t out_item_q;

	// Load the output register whenever it is empty or being drained
	assign pop = !qstat.empty && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_item_q <= head_item;
	end

	// Pack fields: data, status, opcode, count, then zero fill
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(xcfr_pkg::ODATA_W - xcfr_pkg::ODATA_RAW_W){1'b0}},
		out_item_q.count, out_item_q.opcode, out_item_q.status, out_item_q.data};
	assign m_axis_tuser  = out_item_q.kind;
	assign m_axis_tlast  = (out_item_q.kind == xcfr_pkg::KIND_STATUS);

endmodule
